// ===== design/kbd_dec_pkg.sv =====
// Shared types, constants and lookup tables for the keyboard scan code decoder.
// Used by keyboard_scan_code_decoder_unit; no dependencies.
package kbd_dec_pkg;

  localparam int KEY_COUNT = 128;
  localparam int KEY_W     = $clog2(KEY_COUNT);
  localparam int CFG_IDX_W = 1;

  // Item modes
  typedef enum logic [1:0] {
    MODE_KEY   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPS_KEY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_KEY = CFG_IDX_W'(1);

  localparam logic [KEY_W-1:0] CAPS_KEY_RST  = KEY_W'(58);
  localparam logic [KEY_W-1:0] SHIFT_KEY_RST = KEY_W'(42);

  localparam logic [7:0] PREFIX_BIT   = 8'h80;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;  // 'a' - 'A'

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       data_byte;
    logic [KEY_W-1:0] query_key;
  } kbd_in_t;

  typedef struct packed {
    logic             key_event;
    logic             is_make;
    logic [KEY_W-1:0] event_code;
    logic [KEY_W-1:0] last_scan_code;
    logic [7:0]       last_character;
    logic             caps_state;
    logic             query_down;
  } kbd_out_t;

  // Unshifted scan code to ASCII
  function automatic logic [7:0] plain_char(input logic [KEY_W-1:0] code);
    logic [7:0] c;
    case (code)
      7'd1:  c = 8'h1B;  7'd2:  c = 8'h31;  7'd3:  c = 8'h32;  7'd4:  c = 8'h33;
      7'd5:  c = 8'h34;  7'd6:  c = 8'h35;  7'd7:  c = 8'h36;  7'd8:  c = 8'h37;
      7'd9:  c = 8'h38;  7'd10: c = 8'h39;  7'd11: c = 8'h30;  7'd12: c = 8'h2D;
      7'd13: c = 8'h5E;  7'd15: c = 8'h08;  7'd16: c = 8'h09;  7'd17: c = 8'h71;
      7'd18: c = 8'h77;  7'd19: c = 8'h65;  7'd20: c = 8'h72;  7'd21: c = 8'h74;
      7'd22: c = 8'h79;  7'd23: c = 8'h75;  7'd24: c = 8'h69;  7'd25: c = 8'h6F;
      7'd26: c = 8'h70;  7'd27: c = 8'h40;  7'd29: c = 8'h0D;  7'd30: c = 8'h61;
      7'd31: c = 8'h73;  7'd32: c = 8'h64;  7'd33: c = 8'h66;  7'd34: c = 8'h67;
      7'd35: c = 8'h68;  7'd36: c = 8'h6A;  7'd37: c = 8'h6B;  7'd38: c = 8'h6C;
      7'd39: c = 8'h3B;  7'd40: c = 8'h3A;  7'd42: c = 8'h7A;  7'd43: c = 8'h78;
      7'd44: c = 8'h63;  7'd45: c = 8'h76;  7'd46: c = 8'h62;  7'd47: c = 8'h6E;
      7'd48: c = 8'h6D;  7'd49: c = 8'h2C;  7'd50: c = 8'h2E;  7'd51: c = 8'h2F;
      7'd53: c = 8'h20;  7'd54: c = 8'h2A;  7'd55: c = 8'h2F;  7'd56: c = 8'h2B;
      7'd57: c = 8'h2D;  7'd58: c = 8'h37;  7'd59: c = 8'h38;  7'd60: c = 8'h39;
      7'd61: c = 8'h3D;  7'd62: c = 8'h34;  7'd63: c = 8'h35;  7'd64: c = 8'h36;
      7'd66: c = 8'h31;  7'd67: c = 8'h32;  7'd68: c = 8'h33;  7'd69: c = 8'h0D;
      7'd70: c = 8'h30;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Shifted scan code to ASCII
  function automatic logic [7:0] shift_char(input logic [KEY_W-1:0] code);
    logic [7:0] c;
    case (code)
      7'd1:  c = 8'h1B;  7'd2:  c = 8'h21;  7'd3:  c = 8'h22;  7'd4:  c = 8'h23;
      7'd5:  c = 8'h24;  7'd6:  c = 8'h25;  7'd7:  c = 8'h26;  7'd8:  c = 8'h27;
      7'd9:  c = 8'h28;  7'd10: c = 8'h29;  7'd12: c = 8'h3D;  7'd13: c = 8'h7E;
      7'd14: c = 8'h7C;  7'd15: c = 8'h08;  7'd16: c = 8'h09;  7'd17: c = 8'h51;
      7'd18: c = 8'h57;  7'd19: c = 8'h45;  7'd20: c = 8'h52;  7'd21: c = 8'h54;
      7'd22: c = 8'h59;  7'd23: c = 8'h55;  7'd24: c = 8'h49;  7'd25: c = 8'h4F;
      7'd26: c = 8'h50;  7'd27: c = 8'h60;  7'd28: c = 8'h7B;  7'd29: c = 8'h0D;
      7'd30: c = 8'h41;  7'd31: c = 8'h53;  7'd32: c = 8'h44;  7'd33: c = 8'h46;
      7'd34: c = 8'h47;  7'd35: c = 8'h48;  7'd36: c = 8'h4A;  7'd37: c = 8'h4B;
      7'd38: c = 8'h4C;  7'd39: c = 8'h2B;  7'd40: c = 8'h2A;  7'd41: c = 8'h7D;
      7'd42: c = 8'h5A;  7'd43: c = 8'h58;  7'd44: c = 8'h43;  7'd45: c = 8'h56;
      7'd46: c = 8'h42;  7'd47: c = 8'h4E;  7'd48: c = 8'h4D;  7'd49: c = 8'h3C;
      7'd50: c = 8'h3E;  7'd51: c = 8'h3F;  7'd52: c = 8'h5F;  7'd53: c = 8'h20;
      7'd54: c = 8'h2A;  7'd55: c = 8'h2F;  7'd56: c = 8'h2B;  7'd57: c = 8'h2D;
      7'd58: c = 8'h37;  7'd59: c = 8'h38;  7'd60: c = 8'h39;  7'd61: c = 8'h3D;
      7'd62: c = 8'h34;  7'd63: c = 8'h35;  7'd66: c = 8'h31;  7'd67: c = 8'h32;
      7'd68: c = 8'h33;  7'd69: c = 8'h0D;  7'd70: c = 8'h30;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/keyboard_scan_code_decoder_unit.sv =====
// Keyboard scan code decoder top level: input register, decode, result register.
// Depends on kbd_dec_pkg (types, config indexes, ASCII tables).

// Takes one item per cycle unless stalled and returns exactly one result item
// for each. An item passes an input register, then one pass of decode logic, then a
// result register, so a result is valid once its item has been decoded into it and
// is held there while the output is stalled; throughput is one item per clock when
// the output is not stalled, set by that single decode pass and the single update
// of the key map. Mode KEY feeds a raw
// keyboard byte: bytes with bit 7 set are held as the prefix, other bytes
// complete a make or break event. Mode QUERY reports one key's down bit, mode
// CLEAR wipes the key map and the last-scan/last-character registers (caps lock
// and the held prefix survive). The 128-entry key map is a flop vector, so a
// clear wipes it as a whole and no clearing pass follows reset. The two
// config registers (caps key, shift key) are written through the cfg channel,
// which is always ready; write them only while no item is in flight.
module keyboard_scan_code_decoder_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  kbd_dec_pkg::kbd_in_t                in_item_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output kbd_dec_pkg::kbd_out_t               out_item_o,
  // config writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [kbd_dec_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kbd_dec_pkg::KEY_W-1:0]       cfg_data_i
);
  import kbd_dec_pkg::*;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0] caps_key_q, shift_key_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_key_q  <= CAPS_KEY_RST;
      shift_key_q <= SHIFT_KEY_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_CAPS_KEY)  caps_key_q  <= cfg_data_i;
      if (cfg_index_i == CFG_SHIFT_KEY) shift_key_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register -> decode -> result register
  // ---------------------------------------------------------------------------
  logic     in_valid_q;
  kbd_in_t  in_q;
  logic     out_valid_q;
  kbd_out_t out_q, out_d;
  logic     out_free;   // result register can take a new item this cycle
  logic     fire;       // input register item is decoded and retired

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  // Input register is free when empty or when its item moves on this cycle.
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Decoder state
  // ---------------------------------------------------------------------------
  logic [KEY_COUNT-1:0] key_map_q, key_map_d;
  logic [3:0]           prefix_hi_q, prefix_hi_d;   // only the high nibble matters
  logic                 caps_q, caps_d;
  logic [KEY_W-1:0]     recent_scan_q, recent_scan_d;
  logic [7:0]           recent_char_q, recent_char_d;

  // ---------------------------------------------------------------------------
  // Decode pass
  // ---------------------------------------------------------------------------
  logic             is_key, is_prefix, key_ev, make_ok, make;
  logic             shift_down, query_hit;
  logic [KEY_W-1:0] code;
  logic [7:0]       ch;

  assign is_key    = (in_q.mode == MODE_KEY);
  assign is_prefix = |(in_q.data_byte & PREFIX_BIT);
  assign code      = in_q.data_byte[KEY_W-1:0];
  assign key_ev    = is_key && !is_prefix;
  // Make when prefix bit 4 is clear, or the prefix high nibble is all ones.
  assign make_ok   = !prefix_hi_q[0] || (prefix_hi_q == 4'hF);
  assign make      = key_ev && make_ok;

  // A shift-key make counts in the shift test: a shift-key make reads shifted.
  assign shift_down = key_map_q[shift_key_q] || (make && (code == shift_key_q));
  assign caps_d     = caps_q ^ (make && (code == caps_key_q));
  assign query_hit  = (in_q.mode == MODE_QUERY) && key_map_q[in_q.query_key];

  always_comb begin
    if (shift_down) begin
      ch = shift_char(code);
      if ((ch inside {[8'h41:8'h5A]}) && caps_d) ch = ch + CASE_OFFSET;
    end else begin
      ch = plain_char(code);
      if ((ch inside {[8'h61:8'h7A]}) && caps_d) ch = ch - CASE_OFFSET;
    end
  end

  always_comb begin
    key_map_d     = key_map_q;
    prefix_hi_d   = prefix_hi_q;
    recent_scan_d = recent_scan_q;
    recent_char_d = recent_char_q;
    case (in_q.mode)
      MODE_KEY: begin
        if (is_prefix) begin
          prefix_hi_d = in_q.data_byte[7:4];
        end else if (make) begin
          key_map_d[code] = 1'b1;
          recent_scan_d   = code;
          if (ch != 8'h00) recent_char_d = ch;
        end else begin
          key_map_d[code] = 1'b0;
        end
      end
      MODE_CLEAR: begin
        key_map_d     = '0;
        recent_scan_d = '0;
        recent_char_d = '0;
      end
      default: begin
        // query and the unused mode leave state alone
      end
    endcase
  end

  always_comb begin
    out_d.key_event      = key_ev;
    out_d.is_make        = make;
    out_d.event_code     = key_ev ? code : '0;
    out_d.last_scan_code = recent_scan_d;
    out_d.last_character = recent_char_d;
    out_d.caps_state     = caps_d;
    out_d.query_down     = query_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_map_q     <= '0;
      prefix_hi_q   <= '0;
      caps_q        <= 1'b0;
      recent_scan_q <= '0;
      recent_char_q <= '0;
    end else if (fire) begin
      key_map_q     <= key_map_d;
      prefix_hi_q   <= prefix_hi_d;
      caps_q        <= caps_d;
      recent_scan_q <= recent_scan_d;
      recent_char_q <= recent_char_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  // Input side only stalls when the result register is full and held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a held result");

  // A clear item empties the key map and the last registers.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_q.mode == MODE_CLEAR)) |=>
      ((key_map_q == '0) && (recent_scan_q == '0) && (recent_char_q == '0)))
    else $error("clear left state behind");

  // A make marks its key down.
  a_make_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && make) |=> key_map_q[$past(code)])
    else $error("make did not set key map bit");

  // Caps lock only changes on a make of the caps key.
  a_caps_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire && make && (code == caps_key_q)) |=> (caps_q == $past(caps_q)))
    else $error("caps state changed without caps key make");
`endif

endmodule
